// File: rtl/core/krc_pkg.sv
package krc_pkg;

	// Field widths
	localparam int OPERAND_W = 31;
	localparam int DATA_W    = 32;
	localparam int DIGIT_W   = 4;
	localparam int REQ_W     = 2;
	localparam int OP_W      = 3;
	localparam int MODE_W    = 2;
	localparam int RADIX_W   = 5;
	localparam int PROD_W    = OPERAND_W + RADIX_W;
	localparam int CNT_W     = $clog2(OPERAND_W + 1);

	// Configuration port
	localparam int ADDR_W  = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_RADIX = 1'b0;

	// Constants
	localparam logic [OPERAND_W-1:0] OPERAND_MAX = {OPERAND_W{1'b1}};
	localparam logic [CNT_W-1:0]     ITER_LAST   = CNT_W'(OPERAND_W);
	localparam logic [RADIX_W-1:0]   RADIX_RESET = RADIX_W'(10);
	localparam logic [RADIX_W-1:0]   RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0]   RADIX_MAX   = RADIX_W'(16);

	// Request kinds
	localparam logic [REQ_W-1:0] REQ_DIGIT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_OPER  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_SOLVE = 2'd2;

	// Operator codes
	localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
	localparam logic [OP_W-1:0] OP_SUB  = 3'd1;
	localparam logic [OP_W-1:0] OP_MUL  = 3'd2;
	localparam logic [OP_W-1:0] OP_DIV  = 3'd3;
	localparam logic [OP_W-1:0] OP_MOD  = 3'd4;
	localparam logic [OP_W-1:0] OP_NONE = 3'd5;

	// Calculator modes
	localparam logic [MODE_W-1:0] MODE_A     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_B     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SOLVE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_AFTER = 2'd3;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} ctrl_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic iter_busy;
	} dp_status_t;

endpackage

// File: rtl/core/keypad_radix_calculator_unit.sv
// Keypad calculator in a configurable radix (2 to 16, register at offset 0, reset 10).
// Each accepted keypad transaction (digit, operator or solve) returns exactly one
// transaction on the response channel with the mode, both operands, the last result
// and the per-event flags. Digit, operator and ignored events, and solves with add,
// subtract or no defined operator, pass through the run, commit and output states
// before the next transaction can be taken; multiply, divide and modulo solves stay
// in run while the shared shift-add multiplier and restoring divider process one
// operand bit per cycle over 31 steps. A new request is taken only when the previous
// response has been loaded into the output register, so a waiting response stalls
// the request side only while a second one is ready.
module keypad_radix_calculator_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Request channel
	input  logic                                  req_valid,
	output logic                                  req_stall,
	input  logic [krc_pkg::REQ_W-1:0]             req_type,
	input  logic [krc_pkg::DIGIT_W-1:0]           digit,
	input  logic [krc_pkg::OP_W-1:0]              op_code,
	// Response channel
	output logic                                  rsp_valid,
	input  logic                                  rsp_stall,
	output logic [krc_pkg::MODE_W-1:0]            mode,
	output logic [krc_pkg::OPERAND_W-1:0]         operand_a,
	output logic [krc_pkg::OPERAND_W-1:0]         operand_b,
	output logic signed [krc_pkg::DATA_W-1:0]     result,
	output logic                                  result_valid,
	output logic                                  div_zero,
	output logic                                  entry_overflow,
	// Configuration port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [krc_pkg::ADDR_W-1:0]            paddr,
	input  logic [krc_pkg::PDATA_W-1:0]           pwdata,
	output logic [krc_pkg::PDATA_W-1:0]           prdata,
	output logic                                  pready
);

	logic [krc_pkg::RADIX_W-1:0]              radix_q;
	logic                                     cfg_wr;
	logic                                     out_free;
	logic                                     out_load;
	krc_pkg::ctrl_cmd_t                       cmd;
	krc_pkg::dp_status_t                      status;

	logic [krc_pkg::MODE_W-1:0]               dp_mode;
	logic [krc_pkg::OPERAND_W-1:0]            dp_operand_a;
	logic [krc_pkg::OPERAND_W-1:0]            dp_operand_b;
	logic signed [krc_pkg::DATA_W-1:0]        dp_result;
	logic                                     dp_result_valid;
	logic                                     dp_div_zero;
	logic                                     dp_entry_overflow;

	logic                                     rsp_valid_q;
	logic [krc_pkg::MODE_W-1:0]               mode_q;
	logic [krc_pkg::OPERAND_W-1:0]            operand_a_q;
	logic [krc_pkg::OPERAND_W-1:0]            operand_b_q;
	logic signed [krc_pkg::DATA_W-1:0]        result_q;
	logic                                     result_valid_q;
	logic                                     div_zero_q;
	logic                                     entry_overflow_q;

	// Configuration register: radix only.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= krc_pkg::RADIX_RESET;
		end else if (cfg_wr && (paddr[krc_pkg::ADDR_W-1] == krc_pkg::REG_RADIX)) begin
			radix_q <= pwdata[krc_pkg::RADIX_W-1:0];
		end
	end

	assign prdata = (paddr[krc_pkg::ADDR_W-1] == krc_pkg::REG_RADIX) ?
		krc_pkg::PDATA_W'(radix_q) : '0;

	krc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.out_free  (out_free),
		.out_load  (out_load),
		.status    (status),
		.cmd       (cmd)
	);

	krc_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.radix          (radix_q),
		.req_type       (req_type),
		.digit          (digit),
		.op_code        (op_code),
		.cmd            (cmd),
		.status         (status),
		.mode           (dp_mode),
		.operand_a      (dp_operand_a),
		.operand_b      (dp_operand_b),
		.result         (dp_result),
		.result_valid   (dp_result_valid),
		.div_zero       (dp_div_zero),
		.entry_overflow (dp_entry_overflow)
	);

	// Output register: holds one response transaction until it is taken.
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			mode_q           <= dp_mode;
			operand_a_q      <= dp_operand_a;
			operand_b_q      <= dp_operand_b;
			result_q         <= dp_result;
			result_valid_q   <= dp_result_valid;
			div_zero_q       <= dp_div_zero;
			entry_overflow_q <= dp_entry_overflow;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign mode           = mode_q;
	assign operand_a      = operand_a_q;
	assign operand_b      = operand_b_q;
	assign result         = result_q;
	assign result_valid   = result_valid_q;
	assign div_zero       = div_zero_q;
	assign entry_overflow = entry_overflow_q;

endmodule

// File: rtl/core/krc_ctrl.sv
module krc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic                out_free,
	output logic                out_load,
	input  krc_pkg::dp_status_t status,
	output krc_pkg::ctrl_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_RUN    = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;
	localparam logic [1:0] ST_OUT    = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	// Next state and commands.
	always_comb begin
		state_nxt  = state_q;
		cmd.load   = 1'b0;
		cmd.step   = 1'b0;
		cmd.commit = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				if (status.iter_busy) begin
					cmd.step = 1'b1;
				end else begin
					state_nxt = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_nxt  = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					out_load  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// A new transaction is taken only when the previous one has been loaded into the output register.
	assign req_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// File: rtl/core/krc_dpath.sv
module krc_dpath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [krc_pkg::RADIX_W-1:0]           radix,
	input  logic [krc_pkg::REQ_W-1:0]             req_type,
	input  logic [krc_pkg::DIGIT_W-1:0]           digit,
	input  logic [krc_pkg::OP_W-1:0]              op_code,
	input  krc_pkg::ctrl_cmd_t                    cmd,
	output krc_pkg::dp_status_t                   status,
	output logic [krc_pkg::MODE_W-1:0]            mode,
	output logic [krc_pkg::OPERAND_W-1:0]         operand_a,
	output logic [krc_pkg::OPERAND_W-1:0]         operand_b,
	output logic signed [krc_pkg::DATA_W-1:0]     result,
	output logic                                  result_valid,
	output logic                                  div_zero,
	output logic                                  entry_overflow
);

	// Architectural state
	logic [krc_pkg::MODE_W-1:0]    mode_q;
	logic [krc_pkg::OPERAND_W-1:0] value_a_q;
	logic [krc_pkg::OPERAND_W-1:0] value_b_q;
	logic [krc_pkg::OP_W-1:0]      pending_op_q;
	logic [krc_pkg::DATA_W-1:0]    result_q;
	logic                          has_result_q;
	logic                          dz_q;
	logic                          ovf_q;

	// Latched transaction
	logic [krc_pkg::REQ_W-1:0]     req_q;
	logic [krc_pkg::DIGIT_W-1:0]   digit_q;
	logic [krc_pkg::OP_W-1:0]      op_q;
	logic [krc_pkg::PROD_W-1:0]    prod_q;

	// Shift-add multiplier and restoring divider registers
	logic [krc_pkg::DATA_W-1:0]    acc_q;
	logic [krc_pkg::DATA_W-1:0]    sh_q;
	logic [krc_pkg::OPERAND_W-1:0] mpl_q;
	logic [krc_pkg::CNT_W-1:0]     cnt_q;

	logic [krc_pkg::RADIX_W-1:0]   radix_eff;
	logic [krc_pkg::OPERAND_W-1:0] entry_val;
	logic                          need_iter;
	logic [krc_pkg::DATA_W-1:0]    trial;
	logic [krc_pkg::DATA_W:0]      trial_diff;
	logic [krc_pkg::PROD_W-1:0]    digit_sum;
	logic                          digit_ok;
	logic                          digit_ovf;
	logic [krc_pkg::DATA_W-1:0]    solve_val;
	logic                          solve_dz;

	// The radix register value is saturated to the supported range.
	always_comb begin
		if (radix < krc_pkg::RADIX_MIN) begin
			radix_eff = krc_pkg::RADIX_MIN;
		end else if (radix > krc_pkg::RADIX_MAX) begin
			radix_eff = krc_pkg::RADIX_MAX;
		end else begin
			radix_eff = radix;
		end
	end

	assign entry_val = (mode_q == krc_pkg::MODE_B) ? value_b_q : value_a_q;

	// Latch the transaction and scale the operand under entry by the radix.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= req_type;
			digit_q <= digit;
			op_q    <= op_code;
			prod_q  <= krc_pkg::PROD_W'(entry_val) * krc_pkg::PROD_W'(radix_eff);
		end
	end

	// Multiply, divide and modulo iterate one operand bit per cycle.
	assign need_iter = (req_q == krc_pkg::REQ_SOLVE) &&
		((pending_op_q == krc_pkg::OP_MUL) || (pending_op_q == krc_pkg::OP_DIV) ||
		 (pending_op_q == krc_pkg::OP_MOD));
	assign status.iter_busy = need_iter && (cnt_q != krc_pkg::ITER_LAST);

	assign trial      = {acc_q[krc_pkg::DATA_W-2:0], sh_q[krc_pkg::OPERAND_W-1]};
	assign trial_diff = {1'b0, trial} - {2'b00, value_b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= '0;
			sh_q  <= {1'b0, value_a_q};
			mpl_q <= value_b_q;
		end else if (cmd.step) begin
			if (pending_op_q == krc_pkg::OP_MUL) begin
				if (mpl_q[0]) begin
					acc_q <= acc_q + sh_q;
				end
				sh_q  <= {sh_q[krc_pkg::DATA_W-2:0], 1'b0};
				mpl_q <= {1'b0, mpl_q[krc_pkg::OPERAND_W-1:1]};
			end else begin
				if (!trial_diff[krc_pkg::DATA_W]) begin
					acc_q <= trial_diff[krc_pkg::DATA_W-1:0];
					sh_q  <= {sh_q[krc_pkg::DATA_W-2:0], 1'b1};
				end else begin
					acc_q <= trial;
					sh_q  <= {sh_q[krc_pkg::DATA_W-2:0], 1'b0};
				end
			end
		end
	end

	// Digit entry: accept the new value only while it fits the operand.
	assign digit_sum = prod_q + krc_pkg::PROD_W'(digit_q);
	assign digit_ok  = ({1'b0, digit_q} < radix_eff);
	assign digit_ovf = (digit_sum > krc_pkg::PROD_W'(krc_pkg::OPERAND_MAX));

	// Solve result, wrapped to the data width.
	always_comb begin
		solve_dz = 1'b0;
		unique case (pending_op_q)
			krc_pkg::OP_ADD: solve_val = {1'b0, value_a_q} + {1'b0, value_b_q};
			krc_pkg::OP_SUB: solve_val = {1'b0, value_a_q} - {1'b0, value_b_q};
			krc_pkg::OP_MUL: solve_val = acc_q;
			krc_pkg::OP_DIV: begin
				solve_dz  = (value_b_q == '0);
				solve_val = solve_dz ? '0 : {1'b0, sh_q[krc_pkg::OPERAND_W-1:0]};
			end
			krc_pkg::OP_MOD: begin
				solve_dz  = (value_b_q == '0);
				solve_val = solve_dz ? '0 : acc_q;
			end
			default: solve_val = '0;
		endcase
	end

	// Commit the transaction to the calculator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= krc_pkg::MODE_A;
			value_a_q    <= '0;
			value_b_q    <= '0;
			pending_op_q <= krc_pkg::OP_NONE;
			result_q     <= '0;
			has_result_q <= 1'b0;
			dz_q         <= 1'b0;
			ovf_q        <= 1'b0;
		end else if (cmd.commit) begin
			dz_q  <= 1'b0;
			ovf_q <= 1'b0;
			unique case (req_q)
				krc_pkg::REQ_DIGIT: begin
					if (digit_ok) begin
						unique case (mode_q)
							krc_pkg::MODE_A: begin
								if (digit_ovf) begin
									ovf_q <= 1'b1;
								end else begin
									value_a_q <= digit_sum[krc_pkg::OPERAND_W-1:0];
								end
							end
							krc_pkg::MODE_B: begin
								if (digit_ovf) begin
									ovf_q <= 1'b1;
								end else begin
									value_b_q <= digit_sum[krc_pkg::OPERAND_W-1:0];
								end
							end
							krc_pkg::MODE_AFTER: begin
								value_a_q    <= krc_pkg::OPERAND_W'(digit_q);
								value_b_q    <= '0;
								pending_op_q <= krc_pkg::OP_NONE;
								result_q     <= '0;
								has_result_q <= 1'b0;
								mode_q       <= krc_pkg::MODE_A;
							end
							default: ;
						endcase
					end
				end
				krc_pkg::REQ_OPER: begin
					pending_op_q <= op_q;
					unique case (mode_q)
						krc_pkg::MODE_A:     mode_q <= krc_pkg::MODE_B;
						krc_pkg::MODE_B:     mode_q <= krc_pkg::MODE_SOLVE;
						krc_pkg::MODE_AFTER: mode_q <= krc_pkg::MODE_A;
						default:             mode_q <= krc_pkg::MODE_SOLVE;
					endcase
				end
				krc_pkg::REQ_SOLVE: begin
					result_q     <= solve_val;
					has_result_q <= 1'b1;
					dz_q         <= solve_dz;
					mode_q       <= krc_pkg::MODE_AFTER;
				end
				default: ;
			endcase
		end
	end

	assign mode           = mode_q;
	assign operand_a      = value_a_q;
	assign operand_b      = value_b_q;
	assign result         = result_q;
	assign result_valid   = has_result_q;
	assign div_zero       = dz_q;
	assign entry_overflow = ovf_q;

	// A solve always leaves the calculator in the after mode.
	a_solve_after: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && (req_q == krc_pkg::REQ_SOLVE)) |=> (mode_q == krc_pkg::MODE_AFTER))
		else $error("solve did not enter the after mode");

	// A division by zero reports a zero result.
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dz_q |-> ((result_q == '0) && has_result_q))
		else $error("division by zero with a nonzero result");

	// A cleared result reads as zero.
	a_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		!has_result_q |-> (result_q == '0))
		else $error("result held without result_valid");

	// The iterative unit steps only for multiply, divide or modulo solves.
	a_step_only_iter: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (need_iter && !cmd.commit))
		else $error("iteration step outside an iterative solve");

endmodule

// File: verif/keypad_radix_calculator_unit_tb.sv
module keypad_radix_calculator_unit_tb;
	import krc_pkg::*;

	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 12;
	localparam int SETTLE_CYCLES = 40;
	localparam int QUIET_LIMIT   = 20000;
	localparam int PHASES        = 10;
	localparam int HALF_PHASE    = 40;

	localparam logic [ADDR_W-1:0] RADIX_ADDR  = ADDR_W'(4 * int'(REG_RADIX));
	localparam logic [REQ_W-1:0]  REQ_IGNORED = 2'd3;

	// One keypad event as it travels on the request channel.
	typedef struct packed {
		logic [REQ_W-1:0]   kind;
		logic [DIGIT_W-1:0] dig;
		logic [OP_W-1:0]    op;
	} key_event_t;

	// What the calculator shows after one event.
	typedef struct packed {
		logic [MODE_W-1:0]    mode;
		logic [OPERAND_W-1:0] a;
		logic [OPERAND_W-1:0] b;
		logic [DATA_W-1:0]    res;
		logic                 res_valid;
		logic                 dz;
		logic                 ovf;
	} calc_view_t;

	logic                  clk            = 1'b0;
	logic                  arst_n         = 1'b0;
	logic                  req_valid      = 1'b0;
	logic                  req_stall;
	logic [REQ_W-1:0]      req_type       = REQ_DIGIT;
	logic [DIGIT_W-1:0]    digit          = '0;
	logic [OP_W-1:0]       op_code        = OP_ADD;
	logic                  rsp_valid;
	logic                  rsp_stall      = 1'b0;
	logic [MODE_W-1:0]     mode;
	logic [OPERAND_W-1:0]  operand_a;
	logic [OPERAND_W-1:0]  operand_b;
	logic signed [DATA_W-1:0] result;
	logic                  result_valid;
	logic                  div_zero;
	logic                  entry_overflow;
	logic                  psel           = 1'b0;
	logic                  penable        = 1'b0;
	logic                  pwrite         = 1'b0;
	logic [ADDR_W-1:0]     paddr          = '0;
	logic [PDATA_W-1:0]    pwdata         = '0;
	logic [PDATA_W-1:0]    prdata;
	logic                  pready;

	// Calculator state as the testbench tracks it.
	logic [MODE_W-1:0]     key_mode    = MODE_A;
	logic [OPERAND_W-1:0]  value_a     = '0;
	logic [OPERAND_W-1:0]  value_b     = '0;
	logic [OP_W-1:0]       chosen_op   = OP_NONE;
	logic [DATA_W-1:0]     held_result = '0;
	logic                  holds_result = 1'b0;
	logic [RADIX_W-1:0]    cfg_radix   = RADIX_RESET;

	key_event_t keypress_q [$];
	calc_view_t expected_views [$];
	key_event_t in_flight;
	int         keys_queued    = 0;
	int         fail_count     = 0;
	int         send_idle_pct  = 0;
	int         recv_stall_pct = 0;

	keypad_radix_calculator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_type(req_type),
		.digit(digit),
		.op_code(op_code),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.mode(mode),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.result(result),
		.result_valid(result_valid),
		.div_zero(div_zero),
		.entry_overflow(entry_overflow),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Clock generation.
	initial begin : clock_gen
		forever begin
			#CLK_HALF clk = ~clk;
		end
	end

	// The register value is saturated into the legal radix range.
	function automatic int unsigned active_radix();
		if (cfg_radix < RADIX_MIN) return RADIX_MIN;
		if (cfg_radix > RADIX_MAX) return RADIX_MAX;
		return cfg_radix;
	endfunction

	// Appends a digit to an operand; returns 1 and leaves it alone on overflow.
	function automatic logic append_digit(inout logic [OPERAND_W-1:0] val,
			input int unsigned d, input int unsigned r);
		logic [63:0] grown;
		grown = 64'(val) * 64'(r) + 64'(d);
		if (grown > 64'(OPERAND_MAX)) return 1'b1;
		val = grown[OPERAND_W-1:0];
		return 1'b0;
	endfunction

	// Applies one accepted event to the tracked state and queues the expected display.
	task automatic apply_keypress(input key_event_t ev);
		int unsigned r;
		logic [63:0] a64;
		logic [63:0] b64;
		logic [63:0] c64;
		calc_view_t view;
		r = active_radix();
		view.dz = 1'b0;
		view.ovf = 1'b0;
		case (ev.kind)
			REQ_DIGIT: begin
				if (ev.dig < r) begin
					case (key_mode)
						MODE_A: view.ovf = append_digit(value_a, ev.dig, r);
						MODE_B: view.ovf = append_digit(value_b, ev.dig, r);
						MODE_AFTER: begin
							value_a = OPERAND_W'(ev.dig);
							value_b = '0;
							chosen_op = OP_NONE;
							held_result = '0;
							holds_result = 1'b0;
							key_mode = MODE_A;
						end
						default: ;
					endcase
				end
			end
			REQ_OPER: begin
				chosen_op = ev.op;
				case (key_mode)
					MODE_A:     key_mode = MODE_B;
					MODE_B:     key_mode = MODE_SOLVE;
					MODE_AFTER: key_mode = MODE_A;
					default: ;
				endcase
			end
			REQ_SOLVE: begin
				a64 = 64'(value_a);
				b64 = 64'(value_b);
				c64 = '0;
				case (chosen_op)
					OP_ADD: c64 = a64 + b64;
					OP_SUB: c64 = a64 - b64;
					OP_MUL: c64 = a64 * b64;
					OP_DIV, OP_MOD: begin
						if (b64 == 0)
							view.dz = 1'b1;
						else
							c64 = (chosen_op == OP_DIV) ? a64 / b64 : a64 % b64;
					end
					default: c64 = '0;
				endcase
				held_result = c64[DATA_W-1:0];
				holds_result = 1'b1;
				key_mode = MODE_AFTER;
			end
			default: ;
		endcase
		view.mode = key_mode;
		view.a = value_a;
		view.b = value_b;
		view.res = held_result;
		view.res_valid = holds_result;
		expected_views.push_back(view);
	endtask

	function automatic void push_key(input logic [REQ_W-1:0] kind,
			input logic [DIGIT_W-1:0] dig, input logic [OP_W-1:0] op);
		key_event_t ev;
		ev.kind = kind;
		ev.dig = dig;
		ev.op = op;
		keypress_q.push_back(ev);
		keys_queued++;
	endfunction

	// Mostly legal digits, often the top digit, now and then any code at all.
	function automatic logic [DIGIT_W-1:0] pick_digit(input int unsigned r);
		if ($urandom_range(19) == 0) return DIGIT_W'($urandom_range(15));
		if ($urandom_range(4) == 0) return DIGIT_W'(r - 1);
		return DIGIT_W'($urandom_range(r - 1));
	endfunction

	// Mostly the five real operators, sometimes an undefined code.
	function automatic logic [OP_W-1:0] pick_op();
		if ($urandom_range(9) == 0) return OP_W'($urandom_range(7, 5));
		return OP_W'($urandom_range(4));
	endfunction

	// Queues the digits of one operand; the largest value is followed by one digit too many.
	task automatic push_operand(input bit at_max);
		int unsigned r;
		int n;
		longint unsigned v;
		logic [DIGIT_W-1:0] digs [$];
		r = active_radix();
		if (at_max) begin
			v = OPERAND_MAX;
			while (v != 0) begin
				digs.push_front(DIGIT_W'(v % r));
				v = v / r;
			end
			digs.push_back(pick_digit(r));
		end else begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: n = $urandom_range(3, 1);
				6, 7:             n = $urandom_range(8, 4);
				8:                n = $urandom_range(12, 9);
				default:          n = $urandom_range(34, 20);
			endcase
			repeat (n) digs.push_back(pick_digit(r));
		end
		foreach (digs[i]) push_key(REQ_DIGIT, digs[i], OP_W'($urandom_range(7)));
	endtask

	// One calculation with random content, sometimes broken or replaced by noise.
	task automatic queue_one_calc();
		if ($urandom_range(9) == 0) begin
			push_key(REQ_W'($urandom_range(3)), DIGIT_W'($urandom_range(15)),
				OP_W'($urandom_range(7)));
			return;
		end
		if ($urandom_range(7) != 0) push_operand($urandom_range(11) == 0);
		push_key(REQ_OPER, DIGIT_W'($urandom_range(15)), pick_op());
		if ($urandom_range(7) != 0) push_operand($urandom_range(11) == 0);
		if ($urandom_range(9) == 0)
			push_key(REQ_OPER, DIGIT_W'($urandom_range(15)), pick_op());
		if ($urandom_range(9) == 0)
			push_key(REQ_DIGIT, pick_digit(active_radix()), OP_W'($urandom_range(7)));
		if ($urandom_range(11) != 0)
			push_key(REQ_SOLVE, DIGIT_W'($urandom_range(15)), OP_W'($urandom_range(7)));
	endtask

	task automatic queue_calcs(input int count);
		int stop_at;
		stop_at = keys_queued + count;
		while (keys_queued < stop_at) queue_one_calc();
	endtask

	// Returns once every queued event has been sent and every display checked.
	task automatic wait_drained();
		do @(negedge clk);
		while (keypress_q.size() != 0 || req_valid || expected_views.size() != 0);
	endtask

	// Writes the radix register through a setup and an access phase.
	task automatic write_radix(input logic [RADIX_W-1:0] val);
		logic [PDATA_W-1:0] word;
		word = PDATA_W'(val);
		if ($urandom_range(1) == 1)
			word[PDATA_W-1:RADIX_W] = (PDATA_W - RADIX_W)'($urandom());
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= RADIX_ADDR;
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cfg_radix = val;
	endtask

	task automatic check_field(input string name, input longint want_v, input longint got_v);
		if (want_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			fail_count++;
		end
	endtask

	// Request driver: a transaction completes when valid is high and stall is low.
	always @(posedge clk) begin
		if (req_valid && !req_stall)
			apply_keypress(in_flight);
		if (!req_valid || !req_stall) begin
			if (keypress_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_flight = keypress_q.pop_front();
				req_valid <= 1'b1;
				req_type <= in_flight.kind;
				digit <= in_flight.dig;
				op_code <= in_flight.op;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Response monitor: compares each display with the oldest expectation.
	always @(posedge clk) begin : rsp_monitor
		calc_view_t want;
		if (rsp_valid && !rsp_stall) begin
			if (expected_views.size() == 0) begin
				$error("response transaction with no event waiting for it");
				fail_count++;
			end else begin
				want = expected_views.pop_front();
				check_field("mode", want.mode, mode);
				check_field("operand_a", want.a, operand_a);
				check_field("operand_b", want.b, operand_b);
				check_field("result", longint'($signed(want.res)), longint'(result));
				check_field("result_valid", want.res_valid, result_valid);
				check_field("div_zero", want.dz, div_zero);
				check_field("entry_overflow", want.ovf, entry_overflow);
			end
		end
		if (arst_n)
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Watchdog: ends the run after too many cycles with no transaction anywhere.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
					(psel && penable && pwrite && pready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Mismatches found");
		$finish;
	end

	// Stimulus: directed events at the reset radix, then random phases per radix setting.
	initial begin : stimulus
		logic [RADIX_W-1:0] phase_radix [PHASES] = '{
			5'd10, 5'd16, 5'd2, 5'd7, 5'd0, 5'd31, 5'd17, 5'd1, 5'd3, 5'd10
		};
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Ignored digit and request, empty solve, divide by zero, undefined operators,
		// a digit in solve mode, a negative difference and modulo by zero.
		push_key(REQ_DIGIT, 4'd15, OP_ADD);
		push_key(REQ_IGNORED, 4'd0, OP_ADD);
		push_key(REQ_SOLVE, 4'd0, OP_ADD);
		push_key(REQ_DIGIT, 4'd7, OP_ADD);
		push_key(REQ_OPER, 4'd0, OP_DIV);
		push_key(REQ_SOLVE, 4'd0, OP_ADD);
		push_key(REQ_OPER, 4'd0, OP_MUL);
		push_key(REQ_OPER, 4'd0, OP_MOD);
		push_key(REQ_OPER, 4'd0, 3'd7);
		push_key(REQ_DIGIT, 4'd5, OP_ADD);
		push_key(REQ_SOLVE, 4'd0, OP_ADD);
		push_key(REQ_DIGIT, 4'd0, OP_ADD);
		push_key(REQ_OPER, 4'd0, OP_SUB);
		push_key(REQ_DIGIT, 4'd9, OP_ADD);
		push_key(REQ_SOLVE, 4'd0, OP_ADD);
		push_key(REQ_DIGIT, 4'd2, OP_ADD);
		push_key(REQ_OPER, 4'd0, OP_MUL);
		push_key(REQ_DIGIT, 4'd9, OP_ADD);
		push_key(REQ_SOLVE, 4'd0, OP_ADD);
		push_key(REQ_DIGIT, 4'd1, OP_ADD);
		push_key(REQ_OPER, 4'd0, OP_ADD);
		push_key(REQ_OPER, 4'd0, OP_MOD);
		push_key(REQ_SOLVE, 4'd0, OP_ADD);
		push_key(REQ_OPER, 4'd0, 3'd6);
		push_key(REQ_SOLVE, 4'd15, 3'd7);
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			if (p != 0) begin
				repeat (SETTLE_CYCLES) @(posedge clk);
				write_radix(phase_radix[p]);
				@(negedge clk);
			end
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 79;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 79;
				end
				default: begin
					send_idle_pct = 35;
					recv_stall_pct = 35;
				end
			endcase
			// The sender holds off in the middle of each phase until all displays are in.
			queue_calcs(HALF_PHASE);
			wait_drained();
			queue_calcs(HALF_PHASE);
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/krc_pkg.sv
rtl/core/krc_ctrl.sv
rtl/core/krc_dpath.sv
rtl/core/keypad_radix_calculator_unit.sv
verif/keypad_radix_calculator_unit_tb.sv
